// ===== rtl/tbc_pkg.sv =====
// Shared types, constants and state codes for the thermistor Beta converter.
package tbc_pkg;

  localparam int unsigned SAMPLE_COUNT_DEF   = 16;
  localparam int unsigned ADC_FULL_SCALE_DEF = 4095;

  localparam int SAMPLE_W = 12;
  localparam int TEMP_W   = 16;
  localparam int RES_W    = 20;
  localparam int BETA_W   = 15;
  localparam int T0_W     = 15;
  localparam int WR_DATA_W = 20;
  localparam int WR_IDX_W  = 2;

  localparam logic [WR_IDX_W-1:0] REG_SERIES  = 2'd0;
  localparam logic [WR_IDX_W-1:0] REG_NOMINAL = 2'd1;
  localparam logic [WR_IDX_W-1:0] REG_BETA    = 2'd2;
  localparam logic [WR_IDX_W-1:0] REG_T0      = 2'd3;

  localparam logic [RES_W-1:0]  SERIES_RST  = 20'd10000;
  localparam logic [RES_W-1:0]  NOMINAL_RST = 20'd10000;
  localparam logic [BETA_W-1:0] BETA_RST    = 15'd3950;
  localparam logic [T0_W-1:0]   T0_RST      = 15'd2500;

  localparam int RAIL_MARGIN  = 10;
  localparam int KELVIN_CENTI = 27315;

  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 31;
  localparam int MUL_P_W = 64;
  localparam int DIV_W   = 48;
  localparam int FRAC_W  = 30;
  localparam int LOG_W   = 35;
  localparam int DIFF_W  = 38;
  localparam int INV_W   = 49;

  localparam logic [MUL_B_W-1:0] LN2_Q28   = 31'd186065279;
  localparam logic [DIV_W-1:0]   INV_SCALE = 48'h640000000000;
  localparam logic [DIV_W-1:0]   CK_SCALE  = 48'hC80000000000;

  typedef struct packed {
    logic [RES_W-1:0]  series;
    logic [RES_W-1:0]  nominal;
    logic [BETA_W-1:0] beta;
    logic [T0_W-1:0]   t0;
  } cfg_t;

  typedef struct packed {
    logic                     valid;
    logic signed [TEMP_W-1:0] temp;
    logic                     in_range;
    logic [SAMPLE_W-1:0]      avg;
  } res_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef enum logic [4:0] {
    S_IDLE, S_AVG_GO, S_AVG_WAIT, S_CHECK, S_LOAD, S_NORM, S_SQ_GO, S_SQ_WAIT,
    S_LOG_ACC, S_LN_GO, S_LN_WAIT, S_TERM_GO, S_TERM_WAIT, S_INV0_GO,
    S_INV0_WAIT, S_INV, S_ZCHK, S_CK_GO, S_CK_WAIT, S_FINAL, S_DONE
  } state_t;

endpackage

// ===== rtl/tbc_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module tbc_mul (
  input  logic                            clk,
  input  logic                            rst,
  input  tbc_pkg::mul_req_t               req,
  output logic                            done,
  output logic [tbc_pkg::MUL_P_W-1:0]     prod
);

  localparam int CNT_W = $clog2(tbc_pkg::MUL_B_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(tbc_pkg::MUL_B_W - 1);

  logic                          busy;
  logic [CNT_W-1:0]              cnt;
  logic [tbc_pkg::MUL_P_W-1:0]   a_sh;
  logic [tbc_pkg::MUL_B_W-1:0]   b_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      prod <= '0;
      a_sh <= tbc_pkg::MUL_P_W'(req.a);
      b_sh <= req.b;
    end else if (busy) begin
      if (b_sh[0]) begin
        prod <= prod + a_sh;
      end
      a_sh <= a_sh << 1;
      b_sh <= b_sh >> 1;
    end
  end

endmodule

// ===== rtl/tbc_div.sv =====
// Restoring divider, one quotient bit per cycle.
module tbc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  tbc_pkg::div_req_t             req,
  output logic                          done,
  output logic [tbc_pkg::DIV_W-1:0]     quo
);

  localparam int W = tbc_pkg::DIV_W;
  localparam int CNT_W = $clog2(W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(W - 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     rem;
  logic [W-1:0]     dvd;
  logic [W-1:0]     dvs;
  logic [W:0]       sh;
  logic [W+1:0]     trial;
  logic             ge;

  assign sh    = {rem, dvd[W-1]};
  assign trial = {1'b0, sh} - {2'b00, dvs};
  assign ge    = ~trial[W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvd <= req.dividend;
      dvs <= req.divisor;
      quo <= '0;
    end else if (busy) begin
      rem <= ge ? trial[W-1:0] : sh[W-1:0];
      dvd <= dvd << 1;
      quo <= {quo[W-2:0], ge};
    end
  end

endmodule

// ===== rtl/tbc_core.sv =====
// Conversion sequencer: average, rail check, log2 by squaring, Beta equation.
module tbc_core #(
  parameter int unsigned SAMPLE_COUNT   = tbc_pkg::SAMPLE_COUNT_DEF,
  parameter int unsigned ADC_FULL_SCALE = tbc_pkg::ADC_FULL_SCALE_DEF,
  localparam int SUM_W = tbc_pkg::SAMPLE_W + $clog2(SAMPLE_COUNT)
) (
  input  logic               clk,
  input  logic               rst,
  input  tbc_pkg::cfg_t      cfg,
  input  logic               start,
  input  logic [SUM_W-1:0]   sum,
  input  logic               take,
  output tbc_pkg::res_t      res,
  output logic               idle
);

  localparam logic [15:0] FS     = 16'(ADC_FULL_SCALE);
  localparam logic [15:0] FS_LOW = FS - 16'(tbc_pkg::RAIL_MARGIN);
  localparam logic [4:0]  IT_LAST = 5'(tbc_pkg::FRAC_W - 1);

  tbc_pkg::state_t state, state_next;

  tbc_pkg::mul_req_t                mul_req;
  tbc_pkg::div_req_t                div_req;
  logic                             mul_done, div_done;
  logic [tbc_pkg::MUL_P_W-1:0]      mul_prod;
  logic [tbc_pkg::DIV_W-1:0]        div_quo;

  logic [SUM_W-1:0]                 sum_q;
  logic [tbc_pkg::SAMPLE_W-1:0]     avg;
  logic                             ok;
  logic [1:0]                       k;
  logic [30:0]                      n;
  logic [4:0]                       p;
  logic [4:0]                       it;
  logic [tbc_pkg::FRAC_W-1:0]       frac;
  logic signed [tbc_pkg::DIFF_W-1:0] diff;
  logic [tbc_pkg::MUL_A_W-1:0]      ln_q30;
  logic [tbc_pkg::DIV_W-1:0]        term;
  logic [tbc_pkg::DIV_W-1:0]        inv0;
  logic signed [tbc_pkg::INV_W-1:0] inv;
  logic [tbc_pkg::DIV_W-1:0]        quo_ck;
  logic signed [tbc_pkg::TEMP_W-1:0] temp;

  logic [tbc_pkg::RES_W-1:0]        s_eff, r0_eff, log_in;
  logic [tbc_pkg::BETA_W-1:0]       b_eff;
  logic [16:0]                      t0c;
  logic [15:0]                      fa;
  logic                             bad;
  logic [31:0]                      m32;
  logic [tbc_pkg::LOG_W-1:0]        log_val;
  logic [tbc_pkg::DIFF_W-1:0]       neg_diff;
  logic [tbc_pkg::MUL_A_W-1:0]      mag;
  logic signed [tbc_pkg::INV_W-1:0] inv_sum, neg_inv;
  logic [tbc_pkg::DIV_W-1:0]        imag;
  logic [tbc_pkg::DIV_W:0]          q1;
  logic signed [49:0]               centik, val;
  logic signed [tbc_pkg::TEMP_W-1:0] sat;

  tbc_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req),
    .done (mul_done),
    .prod (mul_prod)
  );

  tbc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo)
  );

  // operand prep
  assign s_eff  = (cfg.series == '0) ? 20'd1 : cfg.series;
  assign r0_eff = (cfg.nominal == '0) ? 20'd1 : cfg.nominal;
  assign b_eff  = (cfg.beta == '0) ? 15'd1 : cfg.beta;
  assign t0c    = {{2{cfg.t0[14]}}, cfg.t0} + 17'(tbc_pkg::KELVIN_CENTI);
  assign fa     = FS - {4'b0, avg};
  assign bad    = (avg <= 12'(tbc_pkg::RAIL_MARGIN)) || ({4'b0, avg} >= FS_LOW);

  always_comb begin
    case (k)
      2'd0:    log_in = s_eff;
      2'd1:    log_in = {4'b0, fa};
      2'd2:    log_in = {8'b0, avg};
      default: log_in = r0_eff;
    endcase
  end

  assign m32      = mul_prod[61:30];
  assign log_val  = {p, frac};
  assign neg_diff = -diff;
  assign mag      = diff[tbc_pkg::DIFF_W-1] ? neg_diff[tbc_pkg::MUL_A_W-1:0]
                                            : diff[tbc_pkg::MUL_A_W-1:0];
  assign inv_sum  = diff[tbc_pkg::DIFF_W-1] ? $signed({1'b0, inv0}) - $signed({1'b0, term})
                                            : $signed({1'b0, inv0}) + $signed({1'b0, term});
  assign neg_inv  = -inv;
  assign imag     = inv[tbc_pkg::INV_W-1] ? neg_inv[tbc_pkg::DIV_W-1:0]
                                          : inv[tbc_pkg::DIV_W-1:0];
  assign q1       = {1'b0, quo_ck} + 49'd1;
  assign centik   = $signed({2'b00, q1[tbc_pkg::DIV_W:1]});
  assign val      = (inv[tbc_pkg::INV_W-1] ? -centik : centik)
                    - 50'sd27315;

  always_comb begin
    if (val > 50'sd32767) begin
      sat = 16'sd32767;
    end else if (val < -50'sd32768) begin
      sat = -16'sd32768;
    end else begin
      sat = val[15:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tbc_pkg::S_IDLE:      if (start) state_next = tbc_pkg::S_AVG_GO;
      tbc_pkg::S_AVG_GO:    state_next = tbc_pkg::S_AVG_WAIT;
      tbc_pkg::S_AVG_WAIT:  if (div_done) state_next = tbc_pkg::S_CHECK;
      tbc_pkg::S_CHECK:     state_next = bad ? tbc_pkg::S_DONE : tbc_pkg::S_LOAD;
      tbc_pkg::S_LOAD:      state_next = tbc_pkg::S_NORM;
      tbc_pkg::S_NORM:      if (n[30]) state_next = tbc_pkg::S_SQ_GO;
      tbc_pkg::S_SQ_GO:     state_next = tbc_pkg::S_SQ_WAIT;
      tbc_pkg::S_SQ_WAIT: begin
        if (mul_done) begin
          state_next = (it == IT_LAST) ? tbc_pkg::S_LOG_ACC : tbc_pkg::S_SQ_GO;
        end
      end
      tbc_pkg::S_LOG_ACC:   state_next = (k == 2'd3) ? tbc_pkg::S_LN_GO : tbc_pkg::S_LOAD;
      tbc_pkg::S_LN_GO:     state_next = tbc_pkg::S_LN_WAIT;
      tbc_pkg::S_LN_WAIT:   if (mul_done) state_next = tbc_pkg::S_TERM_GO;
      tbc_pkg::S_TERM_GO:   state_next = tbc_pkg::S_TERM_WAIT;
      tbc_pkg::S_TERM_WAIT: if (div_done) state_next = tbc_pkg::S_INV0_GO;
      tbc_pkg::S_INV0_GO:   state_next = tbc_pkg::S_INV0_WAIT;
      tbc_pkg::S_INV0_WAIT: if (div_done) state_next = tbc_pkg::S_INV;
      tbc_pkg::S_INV:       state_next = tbc_pkg::S_ZCHK;
      tbc_pkg::S_ZCHK:      state_next = (inv == '0) ? tbc_pkg::S_DONE : tbc_pkg::S_CK_GO;
      tbc_pkg::S_CK_GO:     state_next = tbc_pkg::S_CK_WAIT;
      tbc_pkg::S_CK_WAIT:   if (div_done) state_next = tbc_pkg::S_FINAL;
      tbc_pkg::S_FINAL:     state_next = tbc_pkg::S_DONE;
      tbc_pkg::S_DONE:      if (take) state_next = tbc_pkg::S_IDLE;
      default:              state_next = tbc_pkg::S_IDLE;
    endcase
  end

  // unit requests and status
  always_comb begin
    mul_req = '0;
    div_req = '0;
    case (state)
      tbc_pkg::S_SQ_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = {5'b0, n};
        mul_req.b     = n;
      end
      tbc_pkg::S_LN_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = mag;
        mul_req.b     = tbc_pkg::LN2_Q28;
      end
      tbc_pkg::S_AVG_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = tbc_pkg::DIV_W'(sum_q);
        div_req.divisor  = tbc_pkg::DIV_W'(SAMPLE_COUNT);
      end
      tbc_pkg::S_TERM_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {2'b00, ln_q30, 10'b0};
        div_req.divisor  = tbc_pkg::DIV_W'(b_eff);
      end
      tbc_pkg::S_INV0_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = tbc_pkg::INV_SCALE;
        div_req.divisor  = tbc_pkg::DIV_W'(t0c);
      end
      tbc_pkg::S_CK_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = tbc_pkg::CK_SCALE;
        div_req.divisor  = imag;
      end
      default: begin
      end
    endcase
    res.valid    = (state == tbc_pkg::S_DONE);
    res.temp     = temp;
    res.in_range = ok;
    res.avg      = avg;
    idle         = (state == tbc_pkg::S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tbc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      tbc_pkg::S_IDLE:      if (start) sum_q <= sum;
      tbc_pkg::S_AVG_WAIT:  if (div_done) avg <= div_quo[tbc_pkg::SAMPLE_W-1:0];
      tbc_pkg::S_CHECK: begin
        ok   <= ~bad;
        temp <= '0;
        diff <= '0;
        k    <= 2'd0;
      end
      tbc_pkg::S_LOAD: begin
        n    <= {11'b0, log_in};
        p    <= 5'd30;
        it   <= '0;
        frac <= '0;
      end
      tbc_pkg::S_NORM: begin
        if (!n[30]) begin
          n <= n << 1;
          p <= p - 1'b1;
        end
      end
      tbc_pkg::S_SQ_WAIT: begin
        if (mul_done) begin
          frac <= {frac[tbc_pkg::FRAC_W-2:0], m32[31]};
          n    <= m32[31] ? m32[31:1] : m32[30:0];
          it   <= it + 1'b1;
        end
      end
      tbc_pkg::S_LOG_ACC: begin
        diff <= k[1] ? diff - $signed(tbc_pkg::DIFF_W'(log_val))
                     : diff + $signed(tbc_pkg::DIFF_W'(log_val));
        k    <= k + 1'b1;
      end
      tbc_pkg::S_LN_WAIT:   if (mul_done) ln_q30 <= mul_prod[63:28];
      tbc_pkg::S_TERM_WAIT: if (div_done) term <= div_quo;
      tbc_pkg::S_INV0_WAIT: if (div_done) inv0 <= div_quo;
      tbc_pkg::S_INV:       inv <= inv_sum;
      tbc_pkg::S_ZCHK:      if (inv == '0) temp <= 16'sd32767;
      tbc_pkg::S_CK_WAIT:   if (div_done) quo_ck <= div_quo;
      tbc_pkg::S_FINAL:     temp <= sat;
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/thermistor_beta_converter.sv =====
// Top level: sample accumulator, configuration registers and result register.
//
// Usage:
//   Samples enter on in_valid/in_ready, one word per cycle while a group is
//   being collected. Every SAMPLE_COUNT-th word closes the group; in_ready
//   then drops while the conversion runs and rises again once the result has
//   moved into the output register.
//   Results leave on out_valid/out_ready: temp_centi, in_range, avg_code.
//   Conversion time is set mostly by the 120 squarings of the bit-serial
//   31-bit multiplier; the four 48-bit serial divisions add to it. An
//   out-of-range group skips from the rail check straight to the result.
//   The output register holds a finished result while the receiver stalls;
//   the next group is collected meanwhile and waits in the sequencer.
//   Registers are written through wr_en/wr_index/wr_data; the user must
//   write them only while idle, as the block itself does no such check.
//   Reset (rst, synchronous) clears the accumulator and loads the default
//   register values: 10 kohm series and nominal, Beta 3950, 25.00 degC.
module thermistor_beta_converter #(
  parameter int unsigned SAMPLE_COUNT   = tbc_pkg::SAMPLE_COUNT_DEF,
  parameter int unsigned ADC_FULL_SCALE = tbc_pkg::ADC_FULL_SCALE_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tbc_pkg::SAMPLE_W-1:0]        sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tbc_pkg::TEMP_W-1:0]   temp_centi,
  output logic                                in_range,
  output logic [tbc_pkg::SAMPLE_W-1:0]        avg_code,
  input  logic                                wr_en,
  input  logic [tbc_pkg::WR_IDX_W-1:0]        wr_index,
  input  logic [tbc_pkg::WR_DATA_W-1:0]       wr_data
);

  localparam int SUM_W = tbc_pkg::SAMPLE_W + $clog2(SAMPLE_COUNT);
  localparam int IDX_W = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLE_COUNT - 1);

  tbc_pkg::cfg_t  cfg;
  tbc_pkg::res_t  res;
  logic [SUM_W-1:0] sum, sum_next;
  logic [IDX_W-1:0] idx;
  logic           accept, last, core_idle, take;

  assign in_ready = core_idle;
  assign accept   = in_valid & in_ready;
  assign last     = (idx == IDX_LAST);
  assign sum_next = sum + SUM_W'(sample);
  assign take     = res.valid & (~out_valid | out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.series  <= tbc_pkg::SERIES_RST;
      cfg.nominal <= tbc_pkg::NOMINAL_RST;
      cfg.beta    <= tbc_pkg::BETA_RST;
      cfg.t0      <= tbc_pkg::T0_RST;
    end else if (wr_en) begin
      case (wr_index)
        tbc_pkg::REG_SERIES:  cfg.series  <= wr_data;
        tbc_pkg::REG_NOMINAL: cfg.nominal <= wr_data;
        tbc_pkg::REG_BETA:    cfg.beta    <= wr_data[tbc_pkg::BETA_W-1:0];
        tbc_pkg::REG_T0:      cfg.t0      <= wr_data[tbc_pkg::T0_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      idx <= '0;
    end else if (accept) begin
      if (last) begin
        sum <= '0;
        idx <= '0;
      end else begin
        sum <= sum_next;
        idx <= idx + 1'b1;
      end
    end
  end

  tbc_core #(
    .SAMPLE_COUNT   (SAMPLE_COUNT),
    .ADC_FULL_SCALE (ADC_FULL_SCALE)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .start (accept & last),
    .sum   (sum_next),
    .take  (take),
    .res   (res),
    .idle  (core_idle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      temp_centi <= res.temp;
      in_range   <= res.in_range;
      avg_code   <= res.avg;
    end
  end

`ifndef SYNTH
  a_zero_when_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_range |-> temp_centi == 16'sd0)
    else $error("out-of-range word carries nonzero temperature");

  a_avg_margin: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_range |-> avg_code > 12'(tbc_pkg::RAIL_MARGIN))
    else $error("in-range word with average at low rail");

  a_busy_after_group: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last |=> !in_ready)
    else $error("sample taken while conversion running");
`endif

endmodule
